FILE: rtl/bcg_pkg.sv
// Shared widths, constants and types for the battery charge gauge.
package bcg_pkg;

    localparam int VCODE_W = 16;    // width of a raw voltage code field
    localparam int CUR_W   = 16;    // width of a raw current code field
    localparam int PCT_W   = 14;    // charge percent, 0.01 % units
    localparam int CAP_W   = 17;    // capacity, 0.1 h units
    localparam int HRS_W   = 17;    // hours left, 0.1 h units
    localparam int CFG_W   = 17;    // widest configuration register
    localparam int IDX_W   = 3;     // configuration register index

    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;
    localparam logic [CAP_W-1:0] CAP_MAX  = 17'd100000;

    // hours = floor((cap * pct + 5000) / 10000), the divide done as a multiply
    // by ceil(2^44 / 10000); exact for dividends below 2^30
    localparam int                  HRS_X_W     = 30;
    localparam int                  HRS_RECIP_W = 31;
    localparam int                  HRS_SHIFT   = 44;
    localparam logic [HRS_X_W-1:0]  HRS_BIAS    = 30'd5000;
    localparam logic [HRS_RECIP_W-1:0] HRS_RECIP = 31'd1759218605;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_EMPTY     = 3'd0;
    localparam logic [IDX_W-1:0] REG_FULL      = 3'd1;
    localparam logic [IDX_W-1:0] REG_KNEE      = 3'd2;
    localparam logic [IDX_W-1:0] REG_TAIL      = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAPACITY  = 3'd4;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd5;

    // reset values of the configuration registers
    localparam logic [VCODE_W-1:0] RST_EMPTY     = 16'd16800;
    localparam logic [VCODE_W-1:0] RST_FULL      = 16'd25760;
    localparam logic [VCODE_W-1:0] RST_KNEE      = 16'd19200;
    localparam logic [PCT_W-1:0]   RST_TAIL      = 14'd1000;
    localparam logic [CAP_W-1:0]   RST_CAPACITY  = 17'd100;
    localparam logic [CUR_W-1:0]   RST_THRESHOLD = 16'hFCCD;   // -819

    // sideband that travels with a sample along the divider cells
    typedef struct packed {
        logic [PCT_W-1:0] base;   // percent offset of the selected segment
        logic [PCT_W-1:0] quot;   // quotient bits resolved so far
        logic             chg;    // charging flag
    } bcg_side_t;

endpackage

FILE: rtl/bcg_front.sv
// Segment selection and dividend build ahead of the divider cells.
module bcg_front #(
    parameter int VW = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [VW-1:0]                      volt,
    input  logic signed [bcg_pkg::CUR_W-1:0]   cur,
    input  logic [VW-1:0]                      empty_v,
    input  logic [VW-1:0]                      full_v,
    input  logic [VW-1:0]                      knee_v,
    input  logic [bcg_pkg::PCT_W-1:0]          tail,
    input  logic signed [bcg_pkg::CUR_W-1:0]   thr,
    output logic                               out_valid,
    output logic [VW+14:0]                     rem,
    output logic [VW:0]                        den,
    output bcg_pkg::bcg_side_t                 side
);

    localparam int PW    = bcg_pkg::PCT_W;
    localparam int NUM_W = VW + 15;
    localparam int PRD_W = PW + VW;

    logic [PW-1:0] tail_sat;
    logic [PW-1:0] rest;
    logic          two_seg;
    logic [PW-1:0] base_next;
    logic [PW-1:0] share_next;
    logic [VW-1:0] off_next;
    logic [VW-1:0] span_next;
    logic          chg_next;

    logic          s1_valid_reg;
    logic [PW-1:0] s1_base_reg;
    logic [PW-1:0] s1_share_reg;
    logic [VW-1:0] s1_off_reg;
    logic [VW-1:0] s1_span_reg;
    logic          s1_chg_reg;

    logic [PRD_W-1:0]   prod;
    logic [NUM_W-1:0]   rem_next;
    logic               valid_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [VW:0]        den_reg;
    bcg_pkg::bcg_side_t side_reg;

    always_comb
    begin
        tail_sat   = (tail > bcg_pkg::PCT_FULL) ? bcg_pkg::PCT_FULL : tail;
        rest       = bcg_pkg::PCT_FULL - tail_sat;
        two_seg    = (empty_v < knee_v) && (knee_v < full_v);
        // a flat result divides 0 by 1 and keeps only the base
        base_next  = '0;
        share_next = '0;
        off_next   = '0;
        span_next  = VW'(1);
        priority if (two_seg)
        begin
            priority if (volt >= full_v)
            begin
                base_next = bcg_pkg::PCT_FULL;
            end
            else if (volt >= knee_v)
            begin
                base_next  = tail_sat;
                share_next = rest;
                off_next   = volt - knee_v;
                span_next  = full_v - knee_v;
            end
            else if (volt > empty_v)
            begin
                share_next = tail_sat;
                off_next   = volt - empty_v;
                span_next  = knee_v - empty_v;
            end
            else
            begin
                base_next = '0;
            end
        end
        else if (full_v == empty_v)
        begin
            base_next = '0;
        end
        else if (full_v > empty_v)
        begin
            priority if (volt >= full_v)
            begin
                base_next = bcg_pkg::PCT_FULL;
            end
            else if (volt > empty_v)
            begin
                share_next = bcg_pkg::PCT_FULL;
                off_next   = volt - empty_v;
                span_next  = full_v - empty_v;
            end
            else
            begin
                base_next = '0;
            end
        end
        else
        begin
            // reversed span: percent falls as voltage rises
            priority if (volt <= full_v)
            begin
                base_next = bcg_pkg::PCT_FULL;
            end
            else if (volt < empty_v)
            begin
                share_next = bcg_pkg::PCT_FULL;
                off_next   = empty_v - volt;
                span_next  = empty_v - full_v;
            end
            else
            begin
                base_next = '0;
            end
        end
        chg_next = (thr > 0) ? (cur >= thr) : (cur <= thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            valid_reg    <= s1_valid_reg;
        end
    end

    // dividend = 2 * share * off + span, divisor = 2 * span (round half up)
    always_comb
    begin
        prod     = PRD_W'(s1_share_reg) * PRD_W'(s1_off_reg);
        rem_next = {prod, 1'b0} + NUM_W'(s1_span_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_base_reg   <= base_next;
        s1_share_reg  <= share_next;
        s1_off_reg    <= off_next;
        s1_span_reg   <= span_next;
        s1_chg_reg    <= chg_next;
        rem_reg       <= rem_next;
        den_reg       <= {s1_span_reg, 1'b0};
        side_reg.base <= s1_base_reg;
        side_reg.quot <= '0;
        side_reg.chg  <= s1_chg_reg;
    end

    assign out_valid = valid_reg;
    assign rem       = rem_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule

FILE: rtl/bcg_div_cell.sv
// One restoring-division cell: resolves a single quotient bit per cycle.
module bcg_div_cell #(
    parameter int NUM_W = 31,
    parameter int DEN_W = 17,
    parameter int BIT   = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   in_rem,
    input  logic [DEN_W-1:0]   in_den,
    input  bcg_pkg::bcg_side_t in_side,
    output logic               out_valid,
    output logic [NUM_W-1:0]   out_rem,
    output logic [DEN_W-1:0]   out_den,
    output bcg_pkg::bcg_side_t out_side
);

    logic [NUM_W-1:0]   den_sh;
    logic               fits;
    logic [NUM_W-1:0]   rem_next;
    bcg_pkg::bcg_side_t side_next;

    logic               valid_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    bcg_pkg::bcg_side_t side_reg;

    always_comb
    begin
        den_sh    = NUM_W'(in_den) << BIT;
        fits      = (in_rem >= den_sh);
        rem_next  = fits ? (in_rem - den_sh) : in_rem;
        side_next = in_side;
        side_next.quot[BIT] = fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= in_den;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

FILE: rtl/bcg_back.sv
// Percent assembly and runtime scaling after the divider cells.
module bcg_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  bcg_pkg::bcg_side_t              in_side,
    input  logic [bcg_pkg::CAP_W-1:0]       capacity,
    output logic                            out_valid,
    output logic [bcg_pkg::PCT_W-1:0]       pct,
    output logic [bcg_pkg::HRS_W-1:0]       hours,
    output logic                            chg
);

    localparam int PW   = bcg_pkg::PCT_W;
    localparam int MW   = bcg_pkg::CAP_W + bcg_pkg::PCT_W;
    localparam int XW   = bcg_pkg::HRS_X_W;
    localparam int PRDW = bcg_pkg::HRS_X_W + bcg_pkg::HRS_RECIP_W;

    logic [bcg_pkg::CAP_W-1:0] cap_sat;
    logic [MW-1:0]             mul;
    logic [PRDW-1:0]           prod;

    logic                      a_valid_reg;
    logic [PW-1:0]             a_pct_reg;
    logic                      a_chg_reg;
    logic                      b_valid_reg;
    logic [PW-1:0]             b_pct_reg;
    logic                      b_chg_reg;
    logic [XW-1:0]             b_x_reg;
    logic                      c_valid_reg;
    logic [PW-1:0]             c_pct_reg;
    logic                      c_chg_reg;
    logic [bcg_pkg::HRS_W-1:0] c_hours_reg;

    always_comb
    begin
        cap_sat = (capacity > bcg_pkg::CAP_MAX) ? bcg_pkg::CAP_MAX : capacity;
        mul     = MW'(cap_sat) * MW'(a_pct_reg);
        prod    = PRDW'(b_x_reg) * PRDW'(bcg_pkg::HRS_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_pct_reg   <= in_side.base + in_side.quot;
        a_chg_reg   <= in_side.chg;
        b_pct_reg   <= a_pct_reg;
        b_chg_reg   <= a_chg_reg;
        b_x_reg     <= XW'(mul) + bcg_pkg::HRS_BIAS;
        c_pct_reg   <= b_pct_reg;
        c_chg_reg   <= b_chg_reg;
        // divide by 10000: multiply by the reciprocal, keep the high bits
        c_hours_reg <= prod[bcg_pkg::HRS_SHIFT +: bcg_pkg::HRS_W];
    end

    assign out_valid = c_valid_reg;
    assign pct       = c_pct_reg;
    assign hours     = c_hours_reg;
    assign chg       = c_chg_reg;

endmodule

FILE: rtl/battery_charge_gauge.sv
// Top level of the battery charge gauge: configuration registers and pipeline.
//
// Usage: present a sample on bus_voltage_code and current_code with start high;
// it is taken at any rising edge where start is high and busy is low. busy
// stays low, so a new transaction may start in every cycle.
// Each transaction yields one result: charge_percent (0.01 %), hours_left
// (0.1 h) and is_charging, shown for exactly one cycle with done high.
// Throughput is one transaction per cycle. The percent division runs through a
// row of 14 cells, one quotient bit each, followed by the runtime multiply
// stages. The receiver cannot stall: results leave in acceptance order, one
// per transaction, in the cycle they reach the end of the pipeline.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (0 empty, 1 full, 2 knee voltage, 3 tail share, 4 capacity, 5 current
// threshold); other indexes are ignored. Write only while no transaction is
// in flight.
// Reset clears the pipeline and loads the default configuration; voltage
// codes use the low VOLTAGE_BITS bits, at most 16.
module battery_charge_gauge #(
    parameter int VOLTAGE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bcg_pkg::VCODE_W-1:0]       bus_voltage_code,
    input  logic signed [bcg_pkg::CUR_W-1:0]  current_code,
    output logic                              done,
    output logic [bcg_pkg::PCT_W-1:0]         charge_percent,
    output logic [bcg_pkg::HRS_W-1:0]         hours_left,
    output logic                              is_charging,
    input  logic                              cfg_write,
    input  logic [bcg_pkg::IDX_W-1:0]         cfg_index,
    input  logic [bcg_pkg::CFG_W-1:0]         cfg_data
);

    localparam int VW    = (VOLTAGE_BITS < bcg_pkg::VCODE_W) ? VOLTAGE_BITS
                                                             : bcg_pkg::VCODE_W;
    localparam int NUM_W = VW + 15;
    localparam int DEN_W = VW + 1;
    localparam int NCELL = bcg_pkg::PCT_W;

    logic [bcg_pkg::VCODE_W-1:0] empty_reg;
    logic [bcg_pkg::VCODE_W-1:0] full_reg;
    logic [bcg_pkg::VCODE_W-1:0] knee_reg;
    logic [bcg_pkg::PCT_W-1:0]   tail_reg;
    logic [bcg_pkg::CAP_W-1:0]   capacity_reg;
    logic [bcg_pkg::CUR_W-1:0]   threshold_reg;

    logic [NCELL:0]                 valid_chain;
    logic [NCELL:0][NUM_W-1:0]      rem_chain;
    logic [NCELL:0][DEN_W-1:0]      den_chain;
    bcg_pkg::bcg_side_t             side_chain [NCELL+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg     <= bcg_pkg::RST_EMPTY;
            full_reg      <= bcg_pkg::RST_FULL;
            knee_reg      <= bcg_pkg::RST_KNEE;
            tail_reg      <= bcg_pkg::RST_TAIL;
            capacity_reg  <= bcg_pkg::RST_CAPACITY;
            threshold_reg <= bcg_pkg::RST_THRESHOLD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bcg_pkg::REG_EMPTY:     empty_reg     <= cfg_data[bcg_pkg::VCODE_W-1:0];
                bcg_pkg::REG_FULL:      full_reg      <= cfg_data[bcg_pkg::VCODE_W-1:0];
                bcg_pkg::REG_KNEE:      knee_reg      <= cfg_data[bcg_pkg::VCODE_W-1:0];
                bcg_pkg::REG_TAIL:      tail_reg      <= cfg_data[bcg_pkg::PCT_W-1:0];
                bcg_pkg::REG_CAPACITY:  capacity_reg  <= cfg_data[bcg_pkg::CAP_W-1:0];
                bcg_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[bcg_pkg::CUR_W-1:0];
                default:                ;   // drop writes to unused indexes
            endcase
        end
    end

    // the pipeline takes a transaction every cycle
    assign busy = 1'b0;

    bcg_front #(
        .VW (VW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .volt      (bus_voltage_code[VW-1:0]),
        .cur       (current_code),
        .empty_v   (empty_reg[VW-1:0]),
        .full_v    (full_reg[VW-1:0]),
        .knee_v    (knee_reg[VW-1:0]),
        .tail      (tail_reg),
        .thr       (threshold_reg),
        .out_valid (valid_chain[0]),
        .rem       (rem_chain[0]),
        .den       (den_chain[0]),
        .side      (side_chain[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        bcg_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .BIT   (NCELL - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[i]),
            .in_rem    (rem_chain[i]),
            .in_den    (den_chain[i]),
            .in_side   (side_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_rem   (rem_chain[i+1]),
            .out_den   (den_chain[i+1]),
            .out_side  (side_chain[i+1])
        );
    end

    bcg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_chain[NCELL]),
        .in_side   (side_chain[NCELL]),
        .capacity  (capacity_reg),
        .out_valid (done),
        .pct       (charge_percent),
        .hours     (hours_left),
        .chg       (is_charging)
    );

endmodule

FILE: tb/sv/battery_charge_gauge_tb.sv
`timescale 1ns / 100ps
// Testbench for the battery charge gauge: directed and random samples checked by a local predictor.
module battery_charge_gauge_tb;
    import bcg_pkg::*;

    localparam int LATENCY           = 19;
    localparam int STALL_LIMIT       = 1000;
    localparam int RANDOM_ITEMS      = 560;
    localparam int ITEMS_PER_SETTING = 80;
    localparam int MAX_REPORTS       = 10;

    // indexes past the last register; writes to them must be dropped
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [PCT_W-1:0] pct;
        logic [HRS_W-1:0] hrs;
        logic             chg;
    } gauge_reading_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [VCODE_W-1:0]        bus_voltage_code;
    logic signed [CUR_W-1:0]   current_code;
    logic                      done;
    logic [PCT_W-1:0]          charge_percent;
    logic [HRS_W-1:0]          hours_left;
    logic                      is_charging;
    logic                      cfg_write;
    logic [IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    // local copy of the configuration registers
    logic [VCODE_W-1:0]        empty_code;
    logic [VCODE_W-1:0]        full_code;
    logic [VCODE_W-1:0]        knee_code;
    logic [PCT_W-1:0]          tail_code;
    logic [CAP_W-1:0]          cap_code;
    logic signed [CUR_W-1:0]   thr_code;

    gauge_reading_t expected_readings[$];
    int idle_pct       = 29;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    battery_charge_gauge DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .bus_voltage_code (bus_voltage_code),
        .current_code     (current_code),
        .done             (done),
        .charge_percent   (charge_percent),
        .hours_left       (hours_left),
        .is_charging      (is_charging),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // round half up of share * off / span
    function automatic longint unsigned round_share(input longint unsigned share,
                                                    input longint unsigned off,
                                                    input longint unsigned span);
        return (2 * share * off + span) / (2 * span);
    endfunction

    function automatic gauge_reading_t compute_reading(input logic [VCODE_W-1:0] v,
                                                       input logic signed [CUR_W-1:0] cur);
        longint unsigned e;
        longint unsigned f;
        longint unsigned k;
        longint unsigned t;
        longint unsigned cap;
        longint unsigned vv;
        longint unsigned pct;
        longint unsigned hrs;
        gauge_reading_t  r;
        e   = empty_code;
        f   = full_code;
        k   = knee_code;
        vv  = v;
        t   = (tail_code > PCT_FULL) ? PCT_FULL : tail_code;
        cap = (cap_code > CAP_MAX) ? CAP_MAX : cap_code;
        if (e < k && k < f)
        begin
            if (vv >= f)
                pct = PCT_FULL;
            else if (vv >= k)
                pct = t + round_share(PCT_FULL - t, vv - k, f - k);
            else if (vv <= e)
                pct = 0;
            else
                pct = round_share(t, vv - e, k - e);
        end
        else if (f == e)
            pct = 0;
        else if (f > e)
        begin
            if (vv <= e)
                pct = 0;
            else if (vv >= f)
                pct = PCT_FULL;
            else
                pct = round_share(PCT_FULL, vv - e, f - e);
        end
        else
        begin
            // reversed span: percent falls as voltage rises
            if (vv >= e)
                pct = 0;
            else if (vv <= f)
                pct = PCT_FULL;
            else
                pct = round_share(PCT_FULL, e - vv, e - f);
        end
        hrs   = (cap * pct + 5000) / 10000;
        r.pct = pct[PCT_W-1:0];
        r.hrs = hrs[HRS_W-1:0];
        r.chg = (thr_code > 0) ? (cur >= thr_code) : (cur <= thr_code);
        return r;
    endfunction

    // check every result against the oldest pending expectation
    always @(posedge clk)
    begin : check_results
        gauge_reading_t want;
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result pct=%0d hrs=%0d chg=%0b",
                             charge_percent, hours_left, is_charging);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (charge_percent !== want.pct || hours_left !== want.hrs
                    || is_charging !== want.chg)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("ERROR: pct exp %0d got %0d, hrs exp %0d got %0d, chg exp %0b got %0b",
                                 want.pct, charge_percent, want.hrs, hours_left,
                                 want.chg, is_charging);
                end
            end
        end
        if (!rst_n || done || (start && !busy))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_sample(input logic [VCODE_W-1:0] v, input logic signed [CUR_W-1:0] cur);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start            <= 1'b1;
        bus_voltage_code <= v;
        current_code     <= cur;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            if (taken)
                expected_readings.push_back(compute_reading(v, cur));
            @(posedge clk);
        end
    endtask

    // drop start, let every transaction in flight come out, then let the pipe empty
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_EMPTY:     empty_code = data[VCODE_W-1:0];
            REG_FULL:      full_code  = data[VCODE_W-1:0];
            REG_KNEE:      knee_code  = data[VCODE_W-1:0];
            REG_TAIL:      tail_code  = data[PCT_W-1:0];
            REG_CAPACITY:  cap_code   = data[CAP_W-1:0];
            REG_THRESHOLD: thr_code   = data[CUR_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic configure_gauge(input logic [CFG_W-1:0] e, input logic [CFG_W-1:0] f,
                                   input logic [CFG_W-1:0] k, input logic [CFG_W-1:0] t,
                                   input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] thr);
        wait_idle();
        write_reg(REG_EMPTY, e);
        write_reg(REG_FULL, f);
        write_reg(REG_KNEE, k);
        write_reg(REG_TAIL, t);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_THRESHOLD, thr);
        cfg_write <= 1'b0;
    endtask

    // reset configuration: both segments, their edges and the current extremes
    task automatic test_default_curve();
        send_sample(16'd0, -16'sd32768);
        send_sample(16'd16800, 16'sd32767);
        send_sample(16'd16801, -16'sd819);
        send_sample(16'd19199, -16'sd818);
        send_sample(16'd19200, 16'sd0);
        send_sample(16'd22480, 16'sd100);
        send_sample(16'd25759, -16'sd820);
        send_sample(16'd25760, 16'sd1);
        send_sample(16'hFFFF, -16'sd1);
    endtask

    // knee out of order, reversed span, zero span
    task automatic test_single_ramp();
        configure_gauge(1000, 5000, 0, 1000, 100, -819);
        send_sample(16'd999, 16'sd0);
        send_sample(16'd3001, 16'sd0);
        send_sample(16'd5001, 16'sd0);
        configure_gauge(5000, 1000, 3000, 1000, 100, -819);
        send_sample(16'd999, 16'sd0);
        send_sample(16'd2999, 16'sd0);
        send_sample(16'd5000, 16'sd0);
        configure_gauge(2000, 2000, 3000, 1000, 100, -819);
        send_sample(16'd2000, 16'sd0);
    endtask

    // tail share and capacity above their limits, and both at zero
    task automatic test_register_limits();
        configure_gauge(0, 65535, 1, 17'h1FFFF, 17'h1FFFF, 0);
        send_sample(16'd0, 16'sd0);
        send_sample(16'd1, 16'sd0);
        send_sample(16'd2, 16'sd0);
        send_sample(16'hFFFF, 16'sd0);
        configure_gauge(0, 65535, 32768, 0, 0, 0);
        send_sample(16'd40000, 16'sd0);
    endtask

    task automatic test_threshold_sign();
        configure_gauge(16800, 25760, 19200, 10000, 100000, 100);
        send_sample(16'd20000, 16'sd99);
        send_sample(16'd20000, 16'sd100);
        configure_gauge(16800, 25760, 19200, 10000, 100000, 0);
        send_sample(16'd20000, 16'sd0);
        send_sample(16'd20000, 16'sd1);
        configure_gauge(16800, 25760, 19200, 5000, 1, -32768);
        send_sample(16'd20000, -16'sd32768);
        send_sample(16'd20000, -16'sd32767);
        configure_gauge(16800, 25760, 19200, 5000, 1, 32767);
        send_sample(16'd20000, 16'sd32767);
    endtask

    task automatic test_ignored_index();
        wait_idle();
        write_reg(REG_SPARE_LO, 17'h1FFFF);
        write_reg(REG_SPARE_HI, 17'h00000);
        cfg_write <= 1'b0;
        send_sample(16'd24000, 16'sd32767);
    endtask

    task automatic randomize_config();
        logic [CFG_W-1:0] e;
        logic [CFG_W-1:0] f;
        logic [CFG_W-1:0] k;
        logic [CFG_W-1:0] t;
        logic [CFG_W-1:0] cap;
        logic [CFG_W-1:0] thr;
        case ($urandom_range(9))
            0, 1, 2:
            begin
                // narrow segments to stress rounding
                e = CFG_W'($urandom_range(0, 65000));
                k = CFG_W'(e + $urandom_range(1, 200));
                f = CFG_W'(k + $urandom_range(1, 200));
            end
            3, 4, 5:
            begin
                e = CFG_W'($urandom_range(0, 40000));
                k = CFG_W'($urandom_range(e + 1, 55000));
                f = CFG_W'($urandom_range(k + 1, 65535));
            end
            6, 7:
            begin
                e = CFG_W'($urandom_range(0, 131071));
                f = CFG_W'($urandom_range(0, 131071));
                k = CFG_W'($urandom_range(0, 131071));
            end
            8:
            begin
                e = 0;
                f = 65535;
                case ($urandom_range(2))
                    0:       k = 0;
                    1:       k = 65535;
                    default: k = CFG_W'($urandom_range(1, 65534));
                endcase
            end
            default:
            begin
                e = CFG_W'($urandom_range(0, 65535));
                f = e;
                k = CFG_W'($urandom_range(0, 65535));
            end
        endcase
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(3))
                    0:       t = 0;
                    1:       t = 10000;
                    2:       t = 16383;
                    default: t = 17'h1FFFF;
                endcase
            end
            1:       t = CFG_W'($urandom_range(0, 131071));
            default: t = CFG_W'($urandom_range(0, 10000));
        endcase
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(2))
                    0:       cap = 0;
                    1:       cap = 100000;
                    default: cap = 17'h1FFFF;
                endcase
            end
            1:       cap = CFG_W'($urandom_range(0, 131071));
            default: cap = CFG_W'($urandom_range(0, 100000));
        endcase
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(4))
                0:       thr = 0;
                1:       thr = 1;
                2:       thr = 17'h07FFF;
                3:       thr = 17'h08000;
                default: thr = 17'h0FFFF;
            endcase
        end
        else
            thr = CFG_W'($urandom_range(0, 131071));
        configure_gauge(e, f, k, t, cap, thr);
    endtask

    task automatic send_random_sample();
        logic [VCODE_W-1:0]      v;
        logic signed [CUR_W-1:0] cur;
        int                      base;
        case ($urandom_range(3))
            0, 1: v = VCODE_W'($urandom);
            2:
            begin
                // hover around a breakpoint
                case ($urandom_range(2))
                    0:       base = int'(empty_code);
                    1:       base = int'(knee_code);
                    default: base = int'(full_code);
                endcase
                v = VCODE_W'(base + int'($urandom_range(0, 8)) - 4);
            end
            default: v = VCODE_W'($urandom_range(empty_code, full_code));
        endcase
        case ($urandom_range(3))
            0, 1: cur = CUR_W'($urandom);
            2:    cur = CUR_W'(int'(thr_code) + int'($urandom_range(0, 4)) - 2);
            default:
            begin
                case ($urandom_range(3))
                    0:       cur = -16'sd32768;
                    1:       cur = 16'sd32767;
                    2:       cur = 16'sd0;
                    default: cur = -16'sd1;
                endcase
            end
        endcase
        send_sample(v, cur);
    endtask

    task automatic test_random_samples(input int sender_idle);
        int sent;
        idle_pct = sender_idle;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            randomize_config();
            repeat (ITEMS_PER_SETTING) send_random_sample();
            sent += ITEMS_PER_SETTING;
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        start            <= 1'b0;
        bus_voltage_code <= '0;
        current_code     <= '0;
        cfg_write        <= 1'b0;
        cfg_index        <= REG_EMPTY;
        cfg_data         <= '0;
        empty_code = RST_EMPTY;
        full_code  = RST_FULL;
        knee_code  = RST_KNEE;
        tail_code  = RST_TAIL;
        cap_code   = RST_CAPACITY;
        thr_code   = RST_THRESHOLD;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_curve();
        test_single_ramp();
        test_register_limits();
        test_threshold_sign();
        test_ignored_index();
        test_random_samples(29);
        test_random_samples(83);
        test_random_samples(0);

        wait_idle();
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
